// File: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define PCC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pcc check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define PCC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pcc check failed");

`endif

// File: sv/pcc_pkg.sv
package pcc_pkg;

	// field and arithmetic widths
	localparam int COORD_W    = 20;
	localparam int DELTA_W    = COORD_W + 1;
	localparam int LEN_W      = 2 * DELTA_W;
	localparam int HALF_W     = LEN_W / 2;
	localparam int PROD_W     = 2 * LEN_W;
	localparam int THR_W      = 16;
	localparam int MIN_W      = 16;
	localparam int NUM_CHUNKS = PROD_W / HALF_W;
	localparam int CHUNK_W    = HALF_W + THR_W;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_TURN_THRESHOLD     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH_PRODUCT = 1'd1;
	localparam logic [THR_W-1:0] TURN_THRESHOLD_RESET     = 16'd716;
	localparam logic [MIN_W-1:0] MIN_LENGTH_PRODUCT_RESET = 16'd0;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic                      last_point;
	} pcc_in_t;

	typedef struct packed {
		logic consistent;
		logic saw_left_turn;
		logic saw_right_turn;
	} pcc_out_t;

	typedef struct packed {
		logic [THR_W-1:0] turn_threshold;
		logic [MIN_W-1:0] min_length_product;
	} pcc_cfg_t;

	// per-vertex control bits decided by the front
	typedef struct packed {
		logic do_turn;
		logic two_plus;
		logic last;
	} pcc_ctl_t;

	typedef struct packed {
		logic signed [DELTA_W-1:0] dx;
		logic signed [DELTA_W-1:0] dy;
		pcc_ctl_t                  ctl;
	} pcc_job_t;

endpackage

// File: sv/pcc_front.sv
module pcc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              point_valid,
	output logic              point_stall,
	input  pcc_pkg::pcc_in_t  point,
	input  logic              queue_full,
	output logic              push,
	output pcc_pkg::pcc_job_t job
);
	import pcc_pkg::*;

	logic signed [COORD_W-1:0] prev_x_q;
	logic signed [COORD_W-1:0] prev_y_q;
	logic [1:0]                count_q;

	assign point_stall = queue_full;
	assign push        = point_valid && !queue_full;

	// segment from the previous vertex and its classification
	always_comb begin
		job.dx = DELTA_W'(point.point_x) - DELTA_W'(prev_x_q);
		job.dy = DELTA_W'(point.point_y) - DELTA_W'(prev_y_q);
		job.ctl.do_turn  = count_q[1];
		job.ctl.two_plus = count_q != 2'd0;
		job.ctl.last     = point.last_point;
	end

	// previous vertex and saturating vertex count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
			count_q  <= '0;
		end else if (push) begin
			prev_x_q <= point.point_x;
			prev_y_q <= point.point_y;
			if (point.last_point) begin
				count_q <= '0;
			end else if (count_q != 2'd3) begin
				count_q <= count_q + 2'd1;
			end
		end
	end

endmodule

// File: sv/pcc_queue.sv
module pcc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pcc_pkg::pcc_job_t push_data,
	input  logic              pop,
	output pcc_pkg::pcc_job_t pop_data,
	output logic              full,
	output logic              empty
);
	import pcc_pkg::*;

	pcc_job_t            entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full     = count_q == QCNT_W'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign pop_data = entries_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/pcc_back.sv
module pcc_back #(
	parameter int THRESH_FRAC = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  pcc_pkg::pcc_job_t job,
	output logic              pop,
	input  pcc_pkg::pcc_cfg_t cfg,
	output logic              result_valid,
	input  logic              result_stall,
	output pcc_pkg::pcc_out_t result
);
	import pcc_pkg::*;

	localparam int XW = PROD_W + ((THRESH_FRAC > THR_W) ? THRESH_FRAC : THR_W);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	pcc_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;

	// previous segment, kept for the next turn
	logic signed [DELTA_W-1:0] pdx_q, pdy_q;
	logic [LEN_W-1:0]          plen_q;

	// stage 1: squares and cross terms
	logic signed [LEN_W-1:0] sqx_c, sqy_c, cr1_c, cr2_c;
	logic signed [LEN_W-1:0] sqx_s1, sqy_s1, cr1_s1, cr2_s1;

	// stage 2: new squared length and cross product magnitude
	logic signed [LEN_W:0] cross_c;
	logic [LEN_W-1:0]      nlen_s2, plen_s2, cmag_s2;
	logic                  cpos_s2, cpos_s3, cpos_s4, cpos_s5, cpos_s6;

	// stage 3: partial products
	logic [LEN_W-1:0] pp_ll_s3, pp_lh_s3, pp_hl_s3, pp_hh_s3;
	logic [LEN_W-1:0] cc_ll_s3, cc_lh_s3, cc_hh_s3;

	// stage 4: full products
	logic [PROD_W-1:0] prod_s4, c2_s4;

	// stage 5: threshold partials and shifted square
	logic [CHUNK_W-1:0] rch_s5 [NUM_CHUNKS];
	logic [XW-1:0]      lhs_s5;
	logic               gtmin_s5;

	// stage 6: right-hand side summed
	logic [XW-1:0] rhs_c, lhs_s6, rhs_s6;
	logic          gtmin_s6;

	logic left_q, right_q;
	logic sharp, left_next, right_next;
	pcc_out_t result_q;
	logic     result_valid_q;

	assign en           = !result_valid_q || !result_stall;
	assign pop          = job_valid && en;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_comb begin
		sqx_c   = job.dx * job.dx;
		sqy_c   = job.dy * job.dy;
		cr1_c   = pdx_q * job.dy;
		cr2_c   = pdy_q * job.dx;
		cross_c = (LEN_W+1)'(cr1_s1) - (LEN_W+1)'(cr2_s1);
	end

	always_comb begin
		rhs_c = '0;
		for (int k = 0; k < NUM_CHUNKS; k++) begin
			rhs_c = rhs_c + (XW'(rch_s5[k]) << (k * HALF_W));
		end
	end

	// turn decision at the end of the pipe
	always_comb begin
		sharp      = ctl_s6.do_turn && gtmin_s6 && (lhs_s6 >= rhs_s6);
		left_next  = left_q || (sharp && cpos_s6);
		right_next = right_q || (sharp && !cpos_s6);
	end

	// datapath registers, frozen while the result waits
	always_ff @(posedge clk) begin
		if (en) begin
			if (pop) begin
				pdx_q  <= job.dx;
				pdy_q  <= job.dy;
				sqx_s1 <= sqx_c;
				sqy_s1 <= sqy_c;
				cr1_s1 <= cr1_c;
				cr2_s1 <= cr2_c;
				ctl_s1 <= job.ctl;
			end
			if (v_s1) begin
				plen_q  <= LEN_W'(sqx_s1) + LEN_W'(sqy_s1);
				nlen_s2 <= LEN_W'(sqx_s1) + LEN_W'(sqy_s1);
				plen_s2 <= plen_q;
				cmag_s2 <= cross_c[LEN_W] ? LEN_W'(-cross_c) : LEN_W'(cross_c);
				cpos_s2 <= !cross_c[LEN_W] && (cross_c != '0);
				ctl_s2  <= ctl_s1;
			end
			pp_ll_s3 <= plen_s2[HALF_W-1:0] * nlen_s2[HALF_W-1:0];
			pp_lh_s3 <= plen_s2[HALF_W-1:0] * nlen_s2[LEN_W-1:HALF_W];
			pp_hl_s3 <= plen_s2[LEN_W-1:HALF_W] * nlen_s2[HALF_W-1:0];
			pp_hh_s3 <= plen_s2[LEN_W-1:HALF_W] * nlen_s2[LEN_W-1:HALF_W];
			cc_ll_s3 <= cmag_s2[HALF_W-1:0] * cmag_s2[HALF_W-1:0];
			cc_lh_s3 <= cmag_s2[HALF_W-1:0] * cmag_s2[LEN_W-1:HALF_W];
			cc_hh_s3 <= cmag_s2[LEN_W-1:HALF_W] * cmag_s2[LEN_W-1:HALF_W];
			cpos_s3  <= cpos_s2;
			ctl_s3   <= ctl_s2;

			prod_s4 <= PROD_W'(pp_ll_s3)
				+ (PROD_W'(pp_lh_s3) << HALF_W)
				+ (PROD_W'(pp_hl_s3) << HALF_W)
				+ (PROD_W'(pp_hh_s3) << (2 * HALF_W));
			c2_s4 <= PROD_W'(cc_ll_s3)
				+ (PROD_W'(cc_lh_s3) << (HALF_W + 1))
				+ (PROD_W'(cc_hh_s3) << (2 * HALF_W));
			cpos_s4 <= cpos_s3;
			ctl_s4  <= ctl_s3;

			for (int k = 0; k < NUM_CHUNKS; k++) begin
				rch_s5[k] <= CHUNK_W'(prod_s4[k*HALF_W +: HALF_W]) * CHUNK_W'(cfg.turn_threshold);
			end
			lhs_s5   <= XW'(c2_s4) << THRESH_FRAC;
			gtmin_s5 <= (prod_s4[PROD_W-1:MIN_W] != '0)
				|| (prod_s4[MIN_W-1:0] > cfg.min_length_product);
			cpos_s5  <= cpos_s4;
			ctl_s5   <= ctl_s4;

			lhs_s6   <= lhs_s5;
			rhs_s6   <= rhs_c;
			gtmin_s6 <= gtmin_s5;
			cpos_s6  <= cpos_s5;
			ctl_s6   <= ctl_s5;

			if (v_s6 && ctl_s6.last) begin
				result_q.consistent     <= ctl_s6.two_plus && !(left_next && right_next);
				result_q.saw_left_turn  <= left_next;
				result_q.saw_right_turn <= right_next;
			end
		end
	end

	// stage valids, turn flags and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			v_s3           <= 1'b0;
			v_s4           <= 1'b0;
			v_s5           <= 1'b0;
			v_s6           <= 1'b0;
			left_q         <= 1'b0;
			right_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (en) begin
			v_s1           <= job_valid;
			v_s2           <= v_s1;
			v_s3           <= v_s2;
			v_s4           <= v_s3;
			v_s5           <= v_s4;
			v_s6           <= v_s5;
			result_valid_q <= v_s6 && ctl_s6.last;
			if (v_s6) begin
				left_q  <= ctl_s6.last ? 1'b0 : left_next;
				right_q <= ctl_s6.last ? 1'b0 : right_next;
			end
		end
	end

endmodule

// File: sv/polyline_curvature_consistency.sv
// Polyline curvature consistency checker.
// Vertices enter on the point channel (point_valid, point_stall, point);
// a vertex is taken at a rising edge with point_valid high and point_stall
// low. The vertex with last_point set closes the polyline and yields one
// request on the result channel (result_valid, result_stall, result); other
// vertices yield nothing.
// The front takes one vertex per cycle while the queue is not full into a
// two-entry queue; the back is a six-stage pipeline (squares and cross terms,
// sums, split partial products of the 42x42 products, their sums, threshold
// partial products, final sum) that also takes one vertex per cycle while no
// stalled result waits, so sustained throughput is one vertex per cycle.
// While result_stall holds a waiting result, the back pipeline freezes, the
// queue fills and then point_stall rises. Threshold registers are written
// through wr_en, wr_index and wr_data while the block is idle; this binds the
// user, as the block does not enforce it. Reset clears the vertex count,
// turn flags, queue and pipeline valids, and loads turn_threshold = 716 and
// min_length_product = 0.
`include "assert_macros.svh"

module polyline_curvature_consistency #(
	parameter int THRESH_FRAC = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                point_valid,
	output logic                                point_stall,
	input  pcc_pkg::pcc_in_t                    point,
	output logic                                result_valid,
	input  logic                                result_stall,
	output pcc_pkg::pcc_out_t                   result,
	input  logic                                wr_en,
	input  logic [pcc_pkg::CFG_IDX_W-1:0]       wr_index,
	input  logic [pcc_pkg::CFG_DATA_W-1:0]      wr_data
);
	import pcc_pkg::*;

	pcc_cfg_t cfg_q;
	pcc_job_t front_job, back_job;
	logic     q_push, q_pop, q_full, q_empty;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.turn_threshold     <= TURN_THRESHOLD_RESET;
			cfg_q.min_length_product <= MIN_LENGTH_PRODUCT_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_TURN_THRESHOLD: begin
					cfg_q.turn_threshold <= THR_W'(wr_data);
				end
				REG_MIN_LENGTH_PRODUCT: begin
					cfg_q.min_length_product <= MIN_W'(wr_data);
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	pcc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_valid (point_valid),
		.point_stall (point_stall),
		.point       (point),
		.queue_full  (q_full),
		.push        (q_push),
		.job         (front_job)
	);

	pcc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (front_job),
		.pop       (q_pop),
		.pop_data  (back_job),
		.full      (q_full),
		.empty     (q_empty)
	);

	pcc_back #(
		.THRESH_FRAC (THRESH_FRAC)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (!q_empty),
		.job          (back_job),
		.pop          (q_pop),
		.cfg          (cfg_q),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// a waiting, stalled result keeps the back from draining the queue
	`PCC_ASSERT_NOW(a_no_pop_while_held, result_valid && result_stall, !q_pop)
	// a consistent polyline never reports turns both ways
	`PCC_ASSERT_NOW(a_consistent_not_mixed, result_valid && result.consistent, !(result.saw_left_turn && result.saw_right_turn))
	// a taken vertex is in the queue on the next cycle
	`PCC_ASSERT_NEXT(a_taken_is_queued, point_valid && !point_stall, !q_empty)

endmodule
